/* src/rbst_pkg.sv */
package rbst_pkg;

  localparam int COORD_BITS    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AXES          = 3;
  localparam int LANES         = 2 * AXES;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } rbst_in_t;

  typedef struct packed {
    logic   hit;
    coord_t entry_distance;
  } rbst_out_t;

  typedef struct packed {
    logic [AXES-1:0]  dzero;
    logic [AXES-1:0]  in_slab;
    logic [LANES-1:0] neg;
  } rbst_side_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

endpackage

/* src/ray_box_slab_test.sv */
// Ray versus axis-aligned box slab test, signed fixed point.
// Input channel: ray_valid, ray_stall, ray (origin, direction, box corners).
// Output channel: result_valid, result_stall, result (hit, entry_distance).
// A transfer happens on a rising edge with valid high and stall low.
// Every ray yields exactly one result, in order.
// From transfer in to transfer out a ray passes one input stage, one restoring
// division stage per quotient bit for the six slab distances, one stage to
// saturate and order near/far, and one stage to combine the axes.
// Throughput: one ray per cycle while the output is not stalled, set by the
// fully pipelined division.
// Each stage holds its own valid bit; a bubble closes up while the output
// waits, so new rays are taken until every stage is occupied.
// When result_stall holds, the result stays put and ray_stall rises only
// once the pipeline is full; nothing is lost or repeated.
// Reset (rst, synchronous) empties the pipeline; no result is presented
// until a new ray comes in.
// A miss reports hit low and entry_distance at the most positive value.
module ray_box_slab_test #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ray_valid,
  output logic                ray_stall,
  input  rbst_pkg::rbst_in_t  ray,
  output logic                result_valid,
  input  logic                result_stall,
  output rbst_pkg::rbst_out_t result
);
  import rbst_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int QW    = C + 1 + FRAC_BITS;
  localparam int DEPTH = QW + 3;
  localparam int CW    = $clog2(DEPTH + 1);

  logic            prep_ready;
  logic            prep_valid;
  logic [C:0]      mag [LANES];
  logic [C-1:0]    dv [AXES];
  rbst_side_t      prep_side;
  logic            div_ready;
  logic            div_valid;
  logic [QW-1:0]   quot [LANES];
  rbst_side_t      div_side;
  logic            res_ready;

  assign ray_stall = !prep_ready;

  rbst_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ray_valid),
    .in_ready  (prep_ready),
    .in_data   (ray),
    .out_valid (prep_valid),
    .out_ready (div_ready),
    .mag       (mag),
    .dv        (dv),
    .side      (prep_side)
  );

  rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (div_ready),
    .mag       (mag),
    .dv        (dv),
    .side_in   (prep_side),
    .out_valid (div_valid),
    .out_ready (res_ready),
    .quot      (quot),
    .side_out  (div_side)
  );

  rbst_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (res_ready),
    .quot      (quot),
    .side      (div_side),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .out_data  (result)
  );

`ifndef SYNTHESIS
  logic [CW-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(ray_valid && !ray_stall)
                           - CW'(result_valid && !result_stall);
    end
  end

  a_miss_max: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> result.entry_distance == COORD_MAX)
    else $error("miss without maximum distance");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(DEPTH))
    else $error("more rays in flight than stages");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    ray_stall |-> result_valid && result_stall)
    else $error("input stalled with output free");

  a_empty_valid: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !result_valid)
    else $error("result with nothing in flight");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");
`endif

endmodule

/* src/rbst_prep.sv */
module rbst_prep (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rbst_pkg::rbst_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rbst_pkg::COORD_BITS:0]   mag [rbst_pkg::LANES],
  output logic [rbst_pkg::COORD_BITS-1:0] dv [rbst_pkg::AXES],
  output rbst_pkg::rbst_side_t      side
);
  import rbst_pkg::*;

  localparam int C = COORD_BITS;

  coord_t o [AXES];
  coord_t d [AXES];
  coord_t lo [AXES];
  coord_t hi [AXES];
  logic [C:0] mag_next [LANES];
  logic [C-1:0] dv_next [AXES];
  rbst_side_t side_next;

  assign o[0] = in_data.origin_x;
  assign o[1] = in_data.origin_y;
  assign o[2] = in_data.origin_z;
  assign d[0] = in_data.dir_x;
  assign d[1] = in_data.dir_y;
  assign d[2] = in_data.dir_z;
  assign lo[0] = in_data.box_min_x;
  assign lo[1] = in_data.box_min_y;
  assign lo[2] = in_data.box_min_z;
  assign hi[0] = in_data.box_max_x;
  assign hi[1] = in_data.box_max_y;
  assign hi[2] = in_data.box_max_z;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic signed [C:0] dn;
    logic signed [C:0] df;
    for (int a = 0; a < AXES; a++) begin
      dn = {lo[a][C-1], lo[a]} - {o[a][C-1], o[a]};
      df = {hi[a][C-1], hi[a]} - {o[a][C-1], o[a]};
      mag_next[2*a]   = dn[C] ? -dn : dn;
      mag_next[2*a+1] = df[C] ? -df : df;
      side_next.neg[2*a]   = dn[C] ^ d[a][C-1];
      side_next.neg[2*a+1] = df[C] ^ d[a][C-1];
      dv_next[a] = d[a][C-1] ? -d[a] : d[a];
      side_next.dzero[a]   = (d[a] == '0);
      side_next.in_slab[a] = !(o[a] < lo[a]) && !(hi[a] < o[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      mag  <= mag_next;
      dv   <= dv_next;
      side <= side_next;
    end
  end

endmodule

/* src/rbst_div.sv */
module rbst_div #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rbst_pkg::COORD_BITS:0]   mag [rbst_pkg::LANES],
  input  logic [rbst_pkg::COORD_BITS-1:0] dv [rbst_pkg::AXES],
  input  rbst_pkg::rbst_side_t      side_in,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rbst_pkg::COORD_BITS+FRAC_BITS:0] quot [rbst_pkg::LANES],
  output rbst_pkg::rbst_side_t      side_out
);
  import rbst_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int QW = C + 1 + FRAC_BITS;
  localparam int RW = C + 1;

  logic [QW:0]    v;
  logic [QW+1:1]  rdy;
  logic [RW-1:0]  rem [QW+1][LANES];
  logic [QW-1:0]  num [QW+1][LANES];
  logic [QW-1:0]  q   [QW+1][LANES];
  logic [C-1:0]   dvs [QW+1][AXES];
  rbst_side_t     sd  [QW+1];

  assign v[0]      = in_valid;
  assign rdy[QW+1] = out_ready;
  assign in_ready  = rdy[1];
  assign sd[0]     = side_in;

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign rem[0][l] = '0;
    assign num[0][l] = {mag[l], {FRAC_BITS{1'b0}}};
    assign q[0][l]   = '0;
  end
  for (genvar a = 0; a < AXES; a++) begin : g_dv
    assign dvs[0][a] = dv[a];
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [RW-1:0] rem_next [LANES];
    logic [QW-1:0] q_next [LANES];

    assign rdy[s] = !v[s] || rdy[s+1];

    always_comb begin
      logic [RW-1:0] r2;
      logic          ge;
      for (int l = 0; l < LANES; l++) begin
        r2 = {rem[s-1][l][RW-2:0], num[s-1][l][QW-1]};
        ge = (r2 >= {1'b0, dvs[s-1][l/2]});
        rem_next[l] = ge ? r2 - {1'b0, dvs[s-1][l/2]} : r2;
        q_next[l]   = {q[s-1][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (rdy[s]) begin
        v[s] <= v[s-1];
      end
      if (rdy[s] && v[s-1]) begin
        for (int l = 0; l < LANES; l++) begin
          rem[s][l] <= rem_next[l];
          num[s][l] <= {num[s-1][l][QW-2:0], 1'b0};
          q[s][l]   <= q_next[l];
        end
        dvs[s] <= dvs[s-1];
        sd[s]  <= sd[s-1];
      end
    end
  end

  assign out_valid = v[QW];
  assign quot      = q[QW];
  assign side_out  = sd[QW];

endmodule

/* src/rbst_resolve.sv */
module rbst_resolve #(
  parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rbst_pkg::COORD_BITS+FRAC_BITS:0] quot [rbst_pkg::LANES],
  input  rbst_pkg::rbst_side_t      side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rbst_pkg::rbst_out_t       out_data
);
  import rbst_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int QW = C + 1 + FRAC_BITS;

  logic            va;
  logic            rdy_a;
  logic            rdy_b;
  coord_t          tn [AXES];
  coord_t          tf [AXES];
  logic [AXES-1:0] ok;
  logic [AXES-1:0] side_hold;
  coord_t          tn_next [AXES];
  coord_t          tf_next [AXES];
  rbst_out_t       out_next;

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_comb begin
    coord_t        t [LANES];
    logic [QW-1:0] lim;
    logic          n;
    for (int l = 0; l < LANES; l++) begin
      n   = side.neg[l];
      lim = {{(QW-C){1'b0}}, n, {(C-1){~n}}};
      if (quot[l] > lim) begin
        t[l] = n ? COORD_MIN : COORD_MAX;
      end else begin
        t[l] = n ? -quot[l][C-1:0] : quot[l][C-1:0];
      end
    end
    for (int a = 0; a < AXES; a++) begin
      if (t[2*a+1] < t[2*a]) begin
        tn_next[a] = t[2*a+1];
        tf_next[a] = t[2*a];
      end else begin
        tn_next[a] = t[2*a];
        tf_next[a] = t[2*a+1];
      end
    end
  end

  always_comb begin
    coord_t t0;
    coord_t t1;
    t0 = COORD_MIN;
    t1 = COORD_MAX;
    for (int a = 0; a < AXES; a++) begin
      if (ok[a]) begin
        if (t0 < tn[a]) t0 = tn[a];
        if (tf[a] < t1) t1 = tf[a];
      end
    end
    out_next.hit            = (&(ok | side_hold)) && !(t1 < t0);
    out_next.entry_distance = out_next.hit ? t0 : COORD_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) va <= in_valid;
      if (rdy_b) out_valid <= va;
    end
    if (rdy_a && in_valid) begin
      tn        <= tn_next;
      tf        <= tf_next;
      ok        <= ~side.dzero;
      side_hold <= side.in_slab;
    end
    if (rdy_b && va) begin
      out_data <= out_next;
    end
  end

endmodule
